[hw/rtl/cms_pkg.sv]
// Package for the channel macro sequencer: beat structs, macro entry type,
// controller states, mode and register codes, and arithmetic constants.
// No dependencies.
package cms_pkg;

  localparam int unsigned PULSE_W  = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Shared multiply-add unit geometry: position times span fits in 20 bits,
  // and the reciprocal of 180 needs 21 bits.
  localparam int unsigned MUL_A_W  = 20;
  localparam int unsigned MUL_B_W  = 21;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned QUOT_W   = 13;

  // floor(x / 180) == (x * RECIP_180) >> RECIP_SHIFT for every x below 2**20.
  localparam logic [MUL_B_W-1:0] RECIP_180   = 21'd1491309;
  localparam int unsigned        RECIP_SHIFT = 28;
  localparam logic [MUL_B_W-1:0] MS_PER_UNIT = 21'd100;

  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd1000;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2000;
  localparam logic [PULSE_W-1:0] PULSE_MAX     = 12'hFFF;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 1'b1;

  localparam logic [1:0] MODE_SET  = 2'd0;
  localparam logic [1:0] MODE_LOAD = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // Flag bits of a macro.
  localparam int unsigned FLAG_RUN    = 0;
  localparam int unsigned FLAG_ACTIVE = 1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         channel;
    logic [PULSE_W-1:0] pulse_value;
    logic [2:0]         macro_index;
    logic [4:0]         trigger_channel;
    logic [4:0]         move_channel;
    logic [7:0]         move_position;
    logic [7:0]         start_delay;
    logic [7:0]         run_duration;
    logic [TIME_W-1:0]  now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               wrote;
    logic [3:0]         out_channel;
    logic [PULSE_W-1:0] out_value;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic [4:0] trig;
    logic [4:0] move;
    logic [7:0] pos;
    logic [7:0] delay;
    logic [7:0] dur;
  } macro_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_START,
    ST_STOP,
    ST_SAVE,
    ST_CHECK,
    ST_MUL1,
    ST_MUL2,
    ST_MAP,
    ST_OUT
  } state_e;

endpackage

[hw/rtl/cms_mul_unit.sv]
// Shared multiply-add unit of the channel macro sequencer: a registered
// product and a registered 32-bit sum of the product's low word and an addend.
// Depends on cms_pkg.
module cms_mul_unit (
  input  logic                              clk_i,
  input  logic [cms_pkg::MUL_A_W-1:0]       a_i,
  input  logic [cms_pkg::MUL_B_W-1:0]       b_i,
  input  logic [cms_pkg::TIME_W-1:0]        c_i,
  output logic [cms_pkg::PROD_W-1:0]        prod_o,
  output logic [cms_pkg::TIME_W-1:0]        sum_o
);

  logic [cms_pkg::PROD_W-1:0] prod_d, prod_q;
  logic [cms_pkg::TIME_W-1:0] sum_d, sum_q;

  always_comb begin
    prod_d = cms_pkg::PROD_W'(a_i) * cms_pkg::PROD_W'(b_i);
    sum_d  = prod_d[cms_pkg::TIME_W-1:0] + c_i;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign prod_o = prod_q;
  assign sum_o  = sum_q;

endmodule

[hw/rtl/cms_chan_regs.sv]
// Channel pulse value register file of the channel macro sequencer:
// one write port, one read port, cleared by reset.
// Depends on cms_pkg.
module cms_chan_regs #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [$clog2(NUM_CHANNELS)-1:0]  waddr_i,
  input  logic [cms_pkg::PULSE_W-1:0]      wdata_i,
  input  logic [$clog2(NUM_CHANNELS)-1:0]  raddr_i,
  output logic [cms_pkg::PULSE_W-1:0]      rdata_o
);

  logic [cms_pkg::PULSE_W-1:0] vals_q [NUM_CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        vals_q[i] <= '0;
      end
    end else if (we_i) begin
      vals_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = vals_q[raddr_i];

endmodule

[hw/rtl/channel_macro_sequencer_core.sv]
// Top level of the channel macro sequencer: controller, macro table and
// timers. Depends on cms_pkg, cms_mul_unit and cms_chan_regs.
//
// A channel write or a macro load is done as its beat is accepted. A tick
// is accepted and then walks the macros in slot order, emitting one result
// beat per macro. Every macro passes through ST_EVAL and ST_OUT; one whose
// trigger holds also passes ST_CHECK to check its time window. One that starts
// also passes ST_START, ST_STOP and ST_SAVE for its start and stop times, and
// one that overrides its channel also passes ST_MUL1, ST_MUL2 and ST_MAP for
// the position mapping. Each result beat waits in ST_OUT for the consumer.
// The single multiply-add unit computes the times and the mapping (product,
// then division by 180 as a reciprocal multiply). No input beat is taken
// while a tick is in progress.
module channel_macro_sequencer_core #(
  parameter int unsigned NUM_MACROS   = 8,
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cms_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cms_pkg::PULSE_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  cms_pkg::in_beat_t                 in_beat_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cms_pkg::out_beat_t                out_beat_o
);

  localparam int unsigned MAC_W = (NUM_MACROS > 1) ? $clog2(NUM_MACROS) : 1;
  localparam int unsigned CH_W  = $clog2(NUM_CHANNELS);
  localparam logic [5:0]  NUM_CH_L  = 6'(NUM_CHANNELS);
  localparam logic [5:0]  NUM_MAC_L = 6'(NUM_MACROS);
  localparam logic [MAC_W-1:0] LAST_IDX = MAC_W'(NUM_MACROS - 1);

  // Configuration registers.
  logic [cms_pkg::PULSE_W-1:0] min_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= cms_pkg::MIN_PULSE_RST;
      max_q <= cms_pkg::MAX_PULSE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cms_pkg::REG_MIN_PULSE: min_q <= cfg_data_i;
        cms_pkg::REG_MAX_PULSE: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Controller and macro state.
  cms_pkg::state_e state_q, state_d;
  logic [MAC_W-1:0]             idx_q, idx_d;
  logic [cms_pkg::TIME_W-1:0]   now_q;
  cms_pkg::macro_t              macro_q [NUM_MACROS];
  logic [1:0]                   flags_q [NUM_MACROS];
  logic [cms_pkg::TIME_W-1:0]   start_q [NUM_MACROS];
  logic [cms_pkg::TIME_W-1:0]   stop_q  [NUM_MACROS];
  cms_pkg::out_beat_t           res_q, res_d;

  logic in_acc;
  assign in_ready_o = (state_q == cms_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Current entry and its derived values.
  cms_pkg::macro_t             ent;
  logic [1:0]                  flags_cur, flags_chk;
  logic [cms_pkg::TIME_W-1:0]  start_cur, stop_cur;
  logic [4:0]                  trig_idx, move_idx;
  logic                        trig_en, move_ok, hit;
  logic [cms_pkg::PULSE_W-1:0] trig_val;

  assign ent       = macro_q[idx_q];
  assign flags_cur = flags_q[idx_q];
  assign start_cur = start_q[idx_q];
  assign stop_cur  = stop_q[idx_q];
  assign trig_idx  = ent.trig - 5'd1;
  assign move_idx  = ent.move - 5'd1;
  assign trig_en   = (ent.trig != 5'd0) && ({1'b0, trig_idx} < NUM_CH_L);
  assign move_ok   = (ent.move != 5'd0) && ({1'b0, move_idx} < NUM_CH_L);
  // value >= max_pulse - 1, with a max_pulse of zero triggering on anything.
  assign hit = ({1'b0, trig_val} + 13'd1) >= {1'b0, max_q};

  always_comb begin
    flags_chk = flags_cur;
    if (now_q >= start_cur) flags_chk[cms_pkg::FLAG_ACTIVE] = 1'b1;
    if (now_q >= stop_cur)  flags_chk[cms_pkg::FLAG_ACTIVE] = 1'b0;
  end

  // Position mapping: min + (pos * (max - min)) / 180, truncated toward zero and clamped to 0..4095.
  logic signed [12:0]           span_s;
  logic                         span_neg;
  logic [cms_pkg::PULSE_W-1:0]  span_mag;
  logic [cms_pkg::QUOT_W-1:0]   quot;
  logic signed [14:0]           map_s;
  logic [cms_pkg::PULSE_W-1:0]  map_val;
  logic [cms_pkg::PROD_W-1:0]   unit_prod;
  logic [cms_pkg::TIME_W-1:0]   unit_sum;

  always_comb begin
    span_s   = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
    span_neg = span_s[12];
    span_mag = span_neg ? cms_pkg::PULSE_W'(-span_s) : span_s[11:0];
    quot     = unit_prod[cms_pkg::RECIP_SHIFT +: cms_pkg::QUOT_W];
    if (span_neg) begin
      map_s = $signed({3'b000, min_q}) - $signed({2'b00, quot});
    end else begin
      map_s = $signed({3'b000, min_q}) + $signed({2'b00, quot});
    end
    if (map_s < 15'sd0) begin
      map_val = '0;
    end else if (map_s > 15'sd4095) begin
      map_val = cms_pkg::PULSE_MAX;
    end else begin
      map_val = map_s[11:0];
    end
  end

  // Shared unit.
  logic [cms_pkg::MUL_A_W-1:0] op_a;
  logic [cms_pkg::MUL_B_W-1:0] op_b;
  logic [cms_pkg::TIME_W-1:0]  op_c;

  cms_mul_unit u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .c_i    (op_c),
    .prod_o (unit_prod),
    .sum_o  (unit_sum)
  );

  // Channel store.
  logic                        ch_we;
  logic [CH_W-1:0]             ch_waddr;
  logic [cms_pkg::PULSE_W-1:0] ch_wdata;

  cms_chan_regs #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_chan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .raddr_i (CH_W'(trig_idx)),
    .rdata_o (trig_val)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cms_pkg::ST_IDLE: begin
        if (in_acc && in_beat_i.mode == cms_pkg::MODE_TICK) state_d = cms_pkg::ST_EVAL;
      end
      cms_pkg::ST_EVAL: begin
        if (!trig_en || !hit) state_d = cms_pkg::ST_OUT;
        else if (flags_cur == 2'b00) state_d = cms_pkg::ST_START;
        else state_d = cms_pkg::ST_CHECK;
      end
      cms_pkg::ST_START: state_d = cms_pkg::ST_STOP;
      cms_pkg::ST_STOP:  state_d = cms_pkg::ST_SAVE;
      cms_pkg::ST_SAVE:  state_d = cms_pkg::ST_CHECK;
      cms_pkg::ST_CHECK: begin
        if (flags_chk[cms_pkg::FLAG_ACTIVE] && move_ok) state_d = cms_pkg::ST_MUL1;
        else state_d = cms_pkg::ST_OUT;
      end
      cms_pkg::ST_MUL1:  state_d = cms_pkg::ST_MUL2;
      cms_pkg::ST_MUL2:  state_d = cms_pkg::ST_MAP;
      cms_pkg::ST_MAP:   state_d = cms_pkg::ST_OUT;
      cms_pkg::ST_OUT: begin
        if (out_ready_i) state_d = (idx_q == LAST_IDX) ? cms_pkg::ST_IDLE : cms_pkg::ST_EVAL;
      end
      default: state_d = cms_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs.
  logic       flags_we, start_we, stop_we, res_ld;
  logic [1:0] flags_wd;
  logic       res_wrote;

  always_comb begin
    flags_we  = 1'b0;
    flags_wd  = 2'b00;
    start_we  = 1'b0;
    stop_we   = 1'b0;
    res_ld    = 1'b0;
    res_wrote = 1'b0;
    op_a      = '0;
    op_b      = '0;
    op_c      = '0;
    ch_we     = 1'b0;
    ch_waddr  = CH_W'(in_beat_i.channel);
    ch_wdata  = in_beat_i.pulse_value;
    idx_d     = idx_q;
    unique case (state_q)
      cms_pkg::ST_IDLE: begin
        idx_d = '0;
        ch_we = in_acc && (in_beat_i.mode == cms_pkg::MODE_SET) &&
                ({2'b00, in_beat_i.channel} < NUM_CH_L);
      end
      cms_pkg::ST_EVAL: begin
        if (!trig_en) begin
          res_ld = 1'b1;
        end else if (!hit) begin
          flags_we = 1'b1;
          res_ld   = 1'b1;
        end else if (flags_cur == 2'b00) begin
          flags_we = 1'b1;
          flags_wd = 2'b01;
        end
      end
      cms_pkg::ST_START: begin
        op_a = cms_pkg::MUL_A_W'(ent.delay);
        op_b = cms_pkg::MS_PER_UNIT;
        op_c = now_q;
      end
      cms_pkg::ST_STOP: begin
        start_we = 1'b1;
        op_a     = cms_pkg::MUL_A_W'(ent.dur);
        op_b     = cms_pkg::MS_PER_UNIT;
        op_c     = unit_sum;
      end
      cms_pkg::ST_SAVE: stop_we = 1'b1;
      cms_pkg::ST_CHECK: begin
        flags_we = 1'b1;
        flags_wd = flags_chk;
        res_ld   = !(flags_chk[cms_pkg::FLAG_ACTIVE] && move_ok);
      end
      cms_pkg::ST_MUL1: begin
        op_a = cms_pkg::MUL_A_W'(ent.pos);
        op_b = cms_pkg::MUL_B_W'(span_mag);
      end
      cms_pkg::ST_MUL2: begin
        op_a = unit_prod[cms_pkg::MUL_A_W-1:0];
        op_b = cms_pkg::RECIP_180;
      end
      cms_pkg::ST_MAP: begin
        ch_we     = 1'b1;
        ch_waddr  = CH_W'(move_idx);
        ch_wdata  = map_val;
        res_ld    = 1'b1;
        res_wrote = 1'b1;
      end
      cms_pkg::ST_OUT: begin
        if (out_ready_i && idx_q != LAST_IDX) idx_d = idx_q + MAC_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d.slot        = cms_pkg::SLOT_W'(idx_q);
    res_d.wrote       = res_wrote;
    res_d.out_channel = res_wrote ? move_idx[3:0] : 4'd0;
    res_d.out_value   = res_wrote ? map_val : '0;
    res_d.last        = (idx_q == LAST_IDX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cms_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) now_q <= in_beat_i.now_ms;
    if (res_ld) res_q <= res_d;
  end

  // Macro table, flags and timers.
  logic load_we;
  assign load_we = in_acc && (in_beat_i.mode == cms_pkg::MODE_LOAD) &&
                   ({3'b000, in_beat_i.macro_index} < NUM_MAC_L);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MACROS; i++) begin
        macro_q[i] <= '0;
        flags_q[i] <= 2'b00;
        start_q[i] <= '0;
        stop_q[i]  <= '0;
      end
    end else begin
      if (load_we) begin
        macro_q[MAC_W'(in_beat_i.macro_index)] <= '{
          trig:  in_beat_i.trigger_channel,
          move:  in_beat_i.move_channel,
          pos:   in_beat_i.move_position,
          delay: in_beat_i.start_delay,
          dur:   in_beat_i.run_duration
        };
        flags_q[MAC_W'(in_beat_i.macro_index)] <= 2'b00;
      end
      if (flags_we) flags_q[idx_q] <= flags_wd;
      if (start_we) start_q[idx_q] <= unit_sum;
      if (stop_we)  stop_q[idx_q]  <= unit_sum;
    end
  end

  assign out_valid_o = (state_q == cms_pkg::ST_OUT);
  assign out_beat_o  = res_q;

  // A tick always starts its walk at the first macro.
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_beat_i.mode == cms_pkg::MODE_TICK) |=>
      (state_q == cms_pkg::ST_EVAL && idx_q == '0))
    else $error("tick did not start at the first macro");

  // The last beat of a tick returns the block to accepting input.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_beat_o.last) |=> in_ready_o)
    else $error("block not ready after last beat of a tick");

  // An override is reported only for a macro whose active flag is set.
  a_wrote_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.wrote) |-> flags_q[idx_q][cms_pkg::FLAG_ACTIVE])
    else $error("override reported for an inactive macro");

  // The beat being presented always reports the macro under the walk.
  a_slot_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.slot == cms_pkg::SLOT_W'(idx_q)))
    else $error("result slot does not match the walked macro");

endmodule
